// ===== rtl/ara_pkg.sv =====
// Shared constants, request and status codes, and controller/datapath
// command and status types for the aligned range allocator.
// No dependencies.
`timescale 1ns / 1ps

package ara_pkg;

	localparam int MAX_RANGES = 64;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int OFF_W      = 48;
	localparam int SZ_W       = OFF_W + 1;
	localparam int AL_W       = 33;
	localparam int DV_W       = SZ_W + 1;
	localparam int DIVC_W     = $clog2(DV_W + 1);

	localparam logic [SZ_W-1:0] SPAN   = SZ_W'(1) << OFF_W;
	localparam logic [SZ_W-1:0] SZ_MAX = '1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	localparam logic [2:0] RQ_FIRST   = 3'd0;
	localparam logic [2:0] RQ_BEST_LO = 3'd1;
	localparam logic [2:0] RQ_BEST_HI = 3'd2;
	localparam logic [2:0] RQ_HIGH    = 3'd3;
	localparam logic [2:0] RQ_RESERVE = 3'd4;
	localparam logic [2:0] RQ_FREE    = 3'd5;
	localparam logic [2:0] RQ_QUERY   = 3'd6;
	localparam logic [2:0] RQ_INIT    = 3'd7;

	typedef enum logic [4:0] {
		C_NOP, C_LATCH, C_CHECK, C_SRD, C_SCAN, C_AT, C_EVAL, C_GPREP, C_GRANT,
		C_INS_RD, C_INS_WR, C_DEL_RD, C_DEL_WR, C_FRD, C_FWAIT, C_LRD, C_LWAIT,
		C_FDEC, C_INIT, C_STCLR, C_STRD, C_STACC
	} ara_cmd_t;

	typedef struct packed {
		logic t_alloc;
		logic t_res;
		logic t_free;
		logic t_query;
		logic t_init;
		logic pre_bad;
		logic free_zero;
		logic full;
		logic idx_end;
		logic div_done;
		logic res_stop;
		logic res_fit;
		logic skip;
		logic first_hit;
		logic found;
		logic g_fail;
		logic g_split;
		logic g_del;
		logic at_pos;
		logic del_end;
		logic k_ge;
		logic k_zero;
		logic f_both;
		logic f_none;
	} ara_sts_t;

endpackage

// ===== rtl/aligned_range_allocator_core.sv =====
// Top level of the aligned range allocator: controller plus datapath.
// Depends on ara_pkg, ara_ctrl, ara_dp (which holds ara_div).
//
// channel   ports                                               handshake
// request   req_type req_bytes req_alignment req_offset         start & !busy
//           min_offset
// result    status result_offset free_bytes largest_free        done, one cycle
//           free_prefix peak_used
// config    cfg_wdata (capacity)                                cfg_we
//
// One request at a time; busy stays high from acceptance until the result cycle.
// Allocations walk the N stored ranges, running each candidate through the
// one-bit-per-cycle remainder unit; table shifts read and then write each
// moved entry on the single read port, and the closing statistics pass reads
// and accumulates each range.
// Reset (arst_n low) empties the table and clears capacity, usage and peak.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module aligned_range_allocator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 req_type,
	input  logic [ara_pkg::SZ_W-1:0]   req_bytes,
	input  logic [ara_pkg::AL_W-1:0]   req_alignment,
	input  logic [ara_pkg::OFF_W-1:0]  req_offset,
	input  logic [ara_pkg::OFF_W-1:0]  min_offset,
	input  logic                       cfg_we,
	input  logic [ara_pkg::SZ_W-1:0]   cfg_wdata,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [ara_pkg::OFF_W-1:0]  result_offset,
	output logic [ara_pkg::SZ_W-1:0]   free_bytes,
	output logic [ara_pkg::SZ_W-1:0]   largest_free,
	output logic [ara_pkg::SZ_W-1:0]   free_prefix,
	output logic [ara_pkg::SZ_W-1:0]   peak_used
);

	ara_pkg::ara_cmd_t cmd;
	ara_pkg::ara_sts_t sts;

	ara_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	ara_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.req_bytes     (req_bytes),
		.req_alignment (req_alignment),
		.req_offset    (req_offset),
		.min_offset    (min_offset),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.status        (status),
		.result_offset (result_offset),
		.free_bytes    (free_bytes),
		.largest_free  (largest_free),
		.free_prefix   (free_prefix),
		.peak_used     (peak_used)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("request not taken up");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

endmodule

// ===== rtl/ara_div.sv =====
// Restoring remainder unit: one dividend bit per cycle.
// Depends on ara_pkg for widths.
`timescale 1ns / 1ps

module ara_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [ara_pkg::DV_W-1:0]  dividend,
	input  logic [ara_pkg::AL_W-1:0]  divisor,
	output logic                      done,
	output logic [ara_pkg::AL_W-1:0]  rem
);

	logic [ara_pkg::DV_W-1:0]   sh_q;
	logic [ara_pkg::AL_W-1:0]   rem_q;
	logic [ara_pkg::AL_W-1:0]   d_q;
	logic [ara_pkg::DIVC_W-1:0] cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [ara_pkg::AL_W:0]     r;
	logic [ara_pkg::AL_W:0]     rd;

	assign r  = {rem_q, sh_q[ara_pkg::DV_W-1]};
	assign rd = r - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sh_q   <= '0;
			rem_q  <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= ara_pkg::DIVC_W'(ara_pkg::DV_W);
				sh_q  <= dividend;
				rem_q <= '0;
				d_q   <= divisor;
			end else if (run_q) begin
				rem_q <= (r >= {1'b0, d_q}) ? rd[ara_pkg::AL_W-1:0] : r[ara_pkg::AL_W-1:0];
				sh_q  <= sh_q << 1;
				cnt_q <= cnt_q - ara_pkg::DIVC_W'(1);
				if (cnt_q == ara_pkg::DIVC_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/ara_dp.sv =====
// Datapath: range table memory, request and statistics registers, fit tests.
// Depends on ara_pkg and ara_div; driven by commands from ara_ctrl.
`timescale 1ns / 1ps

module ara_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ara_pkg::ara_cmd_t          cmd,
	output ara_pkg::ara_sts_t          sts,
	input  logic [2:0]                 req_type,
	input  logic [ara_pkg::SZ_W-1:0]   req_bytes,
	input  logic [ara_pkg::AL_W-1:0]   req_alignment,
	input  logic [ara_pkg::OFF_W-1:0]  req_offset,
	input  logic [ara_pkg::OFF_W-1:0]  min_offset,
	input  logic                       cfg_we,
	input  logic [ara_pkg::SZ_W-1:0]   cfg_wdata,
	output logic [1:0]                 status,
	output logic [ara_pkg::OFF_W-1:0]  result_offset,
	output logic [ara_pkg::SZ_W-1:0]   free_bytes,
	output logic [ara_pkg::SZ_W-1:0]   largest_free,
	output logic [ara_pkg::SZ_W-1:0]   free_prefix,
	output logic [ara_pkg::SZ_W-1:0]   peak_used
);

	typedef logic [ara_pkg::DV_W-1:0]  dv_t;
	typedef logic [ara_pkg::SZ_W-1:0]  sz_t;
	typedef logic [ara_pkg::OFF_W-1:0] off_t;
	typedef logic [ara_pkg::CNT_W-1:0] cnt_t;
	typedef logic [ara_pkg::IDX_W-1:0] idx_t;

	off_t mem_s [ara_pkg::MAX_RANGES];
	sz_t  mem_z [ara_pkg::MAX_RANGES];

	logic [2:0] ty_q;
	sz_t  rb_q, cap_q, used_q, peak_q, largest_q, prefix_q, rd_z_q, sel_z_q;
	sz_t  ins_z_q, lf_z_q, rt_z_q;
	logic [ara_pkg::AL_W-1:0] ra_q;
	off_t ro_q, rm_q, rd_s_q, res_q, sel_s_q, ins_s_q, lf_s_q, rt_s_q;
	cnt_t count_q, idx_q, pos_q;
	idx_t sel_idx_q;
	dv_t  sel_at_q, cand_at_q, lead_q, zb_q;
	logic [1:0] status_q;
	logic found_q, lf_v_q, rt_v_q;

	logic t_alloc, t01, t_res, t_free, full, idx_end, pre_bad;
	logic res_stop, res_fit, skip, ok, better, take, first_hit;
	logic g_split, g_fail, g_del, at_pos, del_end, k_zero, m_l, m_r;
	dv_t  s_x, z_x, b_x, o_x, e_x, v_x, lo_x, res_lead, at_new, c_lead;
	dv_t  trail, endpt, sum_used;
	off_t lo;
	sz_t  nu;
	cnt_t idx_dn, idx_up, pos_dn;
	logic div_go, div_done;
	logic [ara_pkg::AL_W-1:0] div_rem;

	logic rd_en, we;
	idx_t rd_addr, wa;
	off_t wd_s;
	sz_t  wd_z;

	assign t_alloc = !ty_q[2];
	assign t01     = !ty_q[2] && !ty_q[1];
	assign t_res   = ty_q == ara_pkg::RQ_RESERVE;
	assign t_free  = ty_q == ara_pkg::RQ_FREE;
	assign full    = count_q >= cnt_t'(ara_pkg::MAX_RANGES);
	assign idx_end = idx_q == count_q;

	assign s_x  = dv_t'(rd_s_q);
	assign z_x  = dv_t'(rd_z_q);
	assign b_x  = dv_t'(rb_q);
	assign o_x  = dv_t'(ro_q);
	assign e_x  = s_x + z_x;
	assign v_x  = e_x - b_x;
	assign lo   = (rd_s_q > rm_q) ? rd_s_q : rm_q;
	assign lo_x = dv_t'(lo);

	always_comb begin
		pre_bad = 1'b0;
		if (t_alloc)
			pre_bad = ra_q == '0;
		else if (t_res)
			pre_bad = (rb_q == '0) || (o_x + b_x > dv_t'(cap_q));
		else if (t_free)
			pre_bad = o_x + b_x > dv_t'(ara_pkg::SPAN);
	end

	// reserve: the range must hold [offset, offset + bytes)
	assign res_lead = o_x - s_x;
	assign res_stop = ro_q < rd_s_q;
	assign res_fit  = !res_stop && (res_lead <= z_x) && (b_x <= z_x - res_lead);

	assign skip = ((ty_q == ara_pkg::RQ_BEST_HI) && (b_x > z_x)) ||
		((ty_q == ara_pkg::RQ_HIGH) && ((lo_x > e_x) || (b_x > e_x - lo_x)));

	assign div_go = (cmd == ara_pkg::C_SCAN) && t_alloc && !skip;

	ara_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (t01 ? s_x : v_x),
		.divisor  (ra_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// low placement rounds the start up, high placement rounds the top down
	assign at_new = t01 ? ((div_rem == '0) ? s_x : s_x + dv_t'(ra_q - div_rem))
		: v_x - dv_t'(div_rem);
	assign c_lead = cand_at_q - s_x;

	always_comb begin
		ok     = 1'b0;
		better = 1'b1;
		case (ty_q)
			ara_pkg::RQ_FIRST: ok = (c_lead <= z_x) && (b_x <= z_x - c_lead);
			ara_pkg::RQ_BEST_LO: begin
				ok     = (c_lead <= z_x) && (b_x <= z_x - c_lead);
				better = (rd_z_q < sel_z_q) || ((rd_z_q == sel_z_q) && (cand_at_q < sel_at_q));
			end
			ara_pkg::RQ_BEST_HI: begin
				ok     = cand_at_q >= s_x;
				better = (rd_z_q < sel_z_q) || ((rd_z_q == sel_z_q) && (cand_at_q > sel_at_q));
			end
			ara_pkg::RQ_HIGH: begin
				ok     = cand_at_q >= lo_x;
				better = cand_at_q > sel_at_q;
			end
			default: ok = 1'b0;
		endcase
	end

	assign take      = ok && (!found_q || better);
	assign first_hit = (ty_q == ara_pkg::RQ_FIRST) && ok;

	assign trail    = zb_q - lead_q;
	assign g_split  = (lead_q != '0) && (trail != '0);
	assign g_fail   = g_split && full;
	assign g_del    = (lead_q == '0) && (trail == '0);
	assign endpt    = sel_at_q + b_x;
	assign sum_used = dv_t'(used_q) + b_x;
	assign nu       = sum_used[ara_pkg::SZ_W] ? ara_pkg::SZ_MAX : sum_used[ara_pkg::SZ_W-1:0];

	assign idx_dn  = idx_q - cnt_t'(1);
	assign idx_up  = idx_q + cnt_t'(1);
	assign pos_dn  = pos_q - cnt_t'(1);
	assign at_pos  = idx_q == pos_q;
	assign del_end = idx_up == count_q;
	assign k_zero  = pos_q == '0;
	assign m_l = lf_v_q && (dv_t'(lf_s_q) + dv_t'(lf_z_q) == o_x);
	assign m_r = rt_v_q && (o_x + b_x == dv_t'(rt_s_q));

	always_comb begin
		sts           = '0;
		sts.t_alloc   = t_alloc;
		sts.t_res     = t_res;
		sts.t_free    = t_free;
		sts.t_query   = ty_q == ara_pkg::RQ_QUERY;
		sts.t_init    = ty_q == ara_pkg::RQ_INIT;
		sts.pre_bad   = pre_bad;
		sts.free_zero = rb_q == '0;
		sts.full      = full;
		sts.idx_end   = idx_end;
		sts.div_done  = div_done;
		sts.res_stop  = res_stop;
		sts.res_fit   = res_fit;
		sts.skip      = skip;
		sts.first_hit = first_hit;
		sts.found     = found_q;
		sts.g_fail    = g_fail;
		sts.g_split   = g_split;
		sts.g_del     = g_del;
		sts.at_pos    = at_pos;
		sts.del_end   = del_end;
		sts.k_ge      = rd_s_q >= ro_q;
		sts.k_zero    = k_zero;
		sts.f_both    = m_l && m_r;
		sts.f_none    = !m_l && !m_r;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[ara_pkg::IDX_W-1:0];
		we      = 1'b0;
		wa      = idx_q[ara_pkg::IDX_W-1:0];
		wd_s    = rd_s_q;
		wd_z    = rd_z_q;
		case (cmd)
			ara_pkg::C_SRD, ara_pkg::C_FRD, ara_pkg::C_STRD: rd_en = !idx_end;
			ara_pkg::C_INS_RD: begin
				if (at_pos) begin
					we   = 1'b1;
					wa   = pos_q[ara_pkg::IDX_W-1:0];
					wd_s = ins_s_q;
					wd_z = ins_z_q;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_dn[ara_pkg::IDX_W-1:0];
				end
			end
			ara_pkg::C_INS_WR, ara_pkg::C_DEL_WR: we = 1'b1;
			ara_pkg::C_DEL_RD: begin
				rd_en   = !del_end;
				rd_addr = idx_up[ara_pkg::IDX_W-1:0];
			end
			ara_pkg::C_LRD: begin
				rd_en   = !k_zero;
				rd_addr = pos_dn[ara_pkg::IDX_W-1:0];
			end
			ara_pkg::C_GRANT: begin
				we = !g_fail && !g_del;
				wa = sel_idx_q;
				if (lead_q != '0) begin
					wd_s = sel_s_q;
					wd_z = lead_q[ara_pkg::SZ_W-1:0];
				end else begin
					wd_s = endpt[ara_pkg::OFF_W-1:0];
					wd_z = trail[ara_pkg::SZ_W-1:0];
				end
			end
			ara_pkg::C_FDEC: begin
				if (m_l) begin
					we   = 1'b1;
					wa   = pos_dn[ara_pkg::IDX_W-1:0];
					wd_s = lf_s_q;
					wd_z = m_r ? lf_z_q + rb_q + rt_z_q : lf_z_q + rb_q;
				end else if (m_r) begin
					we   = 1'b1;
					wa   = pos_q[ara_pkg::IDX_W-1:0];
					wd_s = ro_q;
					wd_z = rb_q + rt_z_q;
				end
			end
			ara_pkg::C_INIT: begin
				we   = 1'b1;
				wa   = '0;
				wd_s = '0;
				wd_z = cap_q;
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_s[wa] <= wd_s;
			mem_z[wa] <= wd_z;
		end
		if (rd_en) begin
			rd_s_q <= mem_s[rd_addr];
			rd_z_q <= mem_z[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ty_q <= '0; rb_q <= '0; ra_q <= '0; ro_q <= '0; rm_q <= '0;
			cap_q <= '0; used_q <= '0; peak_q <= '0; largest_q <= '0; prefix_q <= '0;
			count_q <= '0; idx_q <= '0; pos_q <= '0; status_q <= ara_pkg::ST_OK;
			res_q <= '0; found_q <= 1'b0; sel_idx_q <= '0; sel_s_q <= '0; sel_z_q <= '0;
			sel_at_q <= '0; cand_at_q <= '0; lead_q <= '0; zb_q <= '0;
			ins_s_q <= '0; ins_z_q <= '0; lf_s_q <= '0; lf_z_q <= '0; rt_s_q <= '0;
			rt_z_q <= '0; lf_v_q <= 1'b0; rt_v_q <= 1'b0;
		end else begin
			if (cfg_we)
				cap_q <= (cfg_wdata > ara_pkg::SPAN) ? ara_pkg::SPAN : cfg_wdata;
			case (cmd)
				ara_pkg::C_LATCH: begin
					ty_q     <= req_type;
					rb_q     <= req_bytes;
					ra_q     <= req_alignment;
					ro_q     <= req_offset;
					rm_q     <= min_offset;
					status_q <= ara_pkg::ST_OK;
					res_q    <= '0;
					found_q  <= 1'b0;
					idx_q    <= '0;
				end
				ara_pkg::C_CHECK: begin
					if (pre_bad)
						status_q <= ara_pkg::ST_BAD;
					else if (t_free && rb_q != '0 && full)
						status_q <= ara_pkg::ST_FULL;
					else if (t_res)
						status_q <= ara_pkg::ST_NOFIT;
				end
				ara_pkg::C_SRD: begin
					if (idx_end && t_alloc && !found_q)
						status_q <= ara_pkg::ST_NOFIT;
				end
				ara_pkg::C_SCAN: begin
					if (t_res) begin
						if (res_fit) begin
							sel_idx_q <= idx_q[ara_pkg::IDX_W-1:0];
							sel_s_q   <= rd_s_q;
							sel_z_q   <= rd_z_q;
							sel_at_q  <= o_x;
						end else if (!res_stop) begin
							idx_q <= idx_up;
						end
					end else if (skip) begin
						idx_q <= idx_up;
					end
				end
				ara_pkg::C_AT: cand_at_q <= at_new;
				ara_pkg::C_EVAL: begin
					if (take) begin
						found_q   <= 1'b1;
						sel_idx_q <= idx_q[ara_pkg::IDX_W-1:0];
						sel_s_q   <= rd_s_q;
						sel_z_q   <= rd_z_q;
						sel_at_q  <= cand_at_q;
					end
					if (!first_hit)
						idx_q <= idx_up;
				end
				ara_pkg::C_GPREP: begin
					lead_q <= sel_at_q - dv_t'(sel_s_q);
					zb_q   <= dv_t'(sel_z_q) - b_x;
				end
				ara_pkg::C_GRANT: begin
					if (g_fail) begin
						status_q <= ara_pkg::ST_FULL;
					end else begin
						status_q <= ara_pkg::ST_OK;
						res_q    <= sel_at_q[ara_pkg::OFF_W-1:0];
						used_q   <= nu;
						if (nu > peak_q)
							peak_q <= nu;
						if (g_split) begin
							pos_q   <= cnt_t'(sel_idx_q) + cnt_t'(1);
							idx_q   <= count_q;
							ins_s_q <= endpt[ara_pkg::OFF_W-1:0];
							ins_z_q <= trail[ara_pkg::SZ_W-1:0];
						end
						if (g_del) begin
							pos_q <= cnt_t'(sel_idx_q);
							idx_q <= cnt_t'(sel_idx_q);
						end
					end
				end
				ara_pkg::C_INS_RD: if (at_pos) count_q <= count_q + cnt_t'(1);
				ara_pkg::C_INS_WR: idx_q <= idx_dn;
				ara_pkg::C_DEL_RD: if (del_end) count_q <= count_q - cnt_t'(1);
				ara_pkg::C_DEL_WR: idx_q <= idx_up;
				ara_pkg::C_FRD: begin
					if (idx_end) begin
						pos_q  <= count_q;
						rt_v_q <= 1'b0;
					end
				end
				ara_pkg::C_FWAIT: begin
					if (rd_s_q >= ro_q) begin
						pos_q  <= idx_q;
						rt_s_q <= rd_s_q;
						rt_z_q <= rd_z_q;
						rt_v_q <= 1'b1;
					end else begin
						idx_q <= idx_up;
					end
				end
				ara_pkg::C_LRD: if (k_zero) lf_v_q <= 1'b0;
				ara_pkg::C_LWAIT: begin
					lf_s_q <= rd_s_q;
					lf_z_q <= rd_z_q;
					lf_v_q <= 1'b1;
				end
				ara_pkg::C_FDEC: begin
					used_q <= (used_q > rb_q) ? used_q - rb_q : '0;
					if (m_l && m_r)
						idx_q <= pos_q;
					if (!m_l && !m_r) begin
						ins_s_q <= ro_q;
						ins_z_q <= rb_q;
						idx_q   <= count_q;
					end
				end
				ara_pkg::C_INIT: begin
					used_q  <= '0;
					peak_q  <= '0;
					count_q <= (cap_q != '0) ? cnt_t'(1) : '0;
				end
				ara_pkg::C_STCLR: begin
					idx_q     <= '0;
					largest_q <= '0;
					prefix_q  <= '0;
				end
				ara_pkg::C_STACC: begin
					if (rd_z_q > largest_q)
						largest_q <= rd_z_q;
					if (idx_q == '0 && rd_s_q == '0)
						prefix_q <= rd_z_q;
					idx_q <= idx_up;
				end
				default: ;
			endcase
		end
	end

	assign status        = status_q;
	assign result_offset = res_q;
	assign free_bytes    = (cap_q > used_q) ? cap_q - used_q : '0;
	assign largest_free  = largest_q;
	assign free_prefix   = prefix_q;
	assign peak_used     = peak_q;

endmodule

// ===== rtl/ara_ctrl.sv =====
// Controller: sequences search, grant, table shifts, merge, init and statistics.
// Depends on ara_pkg; drives ara_dp through command and status types.
`timescale 1ns / 1ps

module ara_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output ara_pkg::ara_cmd_t cmd,
	input  ara_pkg::ara_sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_SRD, S_SCAN, S_SDIV, S_AT, S_EVAL, S_GPREP, S_GRANT,
		S_INSRD, S_INSWR, S_DELRD, S_DELWR, S_FRD, S_FWAIT, S_LRD, S_LWAIT,
		S_FDEC, S_INIT, S_STCLR, S_STRD, S_STACC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_comb begin
		case (state_q)
			S_IDLE:  cmd = start ? ara_pkg::C_LATCH : ara_pkg::C_NOP;
			S_CHECK: cmd = ara_pkg::C_CHECK;
			S_SRD:   cmd = ara_pkg::C_SRD;
			S_SCAN:  cmd = ara_pkg::C_SCAN;
			S_AT:    cmd = ara_pkg::C_AT;
			S_EVAL:  cmd = ara_pkg::C_EVAL;
			S_GPREP: cmd = ara_pkg::C_GPREP;
			S_GRANT: cmd = ara_pkg::C_GRANT;
			S_INSRD: cmd = ara_pkg::C_INS_RD;
			S_INSWR: cmd = ara_pkg::C_INS_WR;
			S_DELRD: cmd = ara_pkg::C_DEL_RD;
			S_DELWR: cmd = ara_pkg::C_DEL_WR;
			S_FRD:   cmd = ara_pkg::C_FRD;
			S_FWAIT: cmd = ara_pkg::C_FWAIT;
			S_LRD:   cmd = ara_pkg::C_LRD;
			S_LWAIT: cmd = ara_pkg::C_LWAIT;
			S_FDEC:  cmd = ara_pkg::C_FDEC;
			S_INIT:  cmd = ara_pkg::C_INIT;
			S_STCLR: cmd = ara_pkg::C_STCLR;
			S_STRD:  cmd = ara_pkg::C_STRD;
			S_STACC: cmd = ara_pkg::C_STACC;
			default: cmd = ara_pkg::C_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.pre_bad || sts.t_query)
						state_q <= S_STCLR;
					else if (sts.t_init)
						state_q <= S_INIT;
					else if (sts.t_free)
						state_q <= (sts.free_zero || sts.full) ? S_STCLR : S_FRD;
					else
						state_q <= S_SRD;
				end
				S_INIT: state_q <= S_STCLR;
				S_SRD: begin
					if (sts.idx_end)
						state_q <= (sts.t_alloc && sts.found) ? S_GPREP : S_STCLR;
					else
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.t_res) begin
						if (sts.res_stop)
							state_q <= S_STCLR;
						else
							state_q <= sts.res_fit ? S_GPREP : S_SRD;
					end else begin
						state_q <= sts.skip ? S_SRD : S_SDIV;
					end
				end
				S_SDIV: if (sts.div_done) state_q <= S_AT;
				S_AT:   state_q <= S_EVAL;
				S_EVAL: state_q <= sts.first_hit ? S_GPREP : S_SRD;
				S_GPREP: state_q <= S_GRANT;
				S_GRANT: begin
					if (sts.g_fail)
						state_q <= S_STCLR;
					else if (sts.g_split)
						state_q <= S_INSRD;
					else if (sts.g_del)
						state_q <= S_DELRD;
					else
						state_q <= S_STCLR;
				end
				S_INSRD: state_q <= sts.at_pos ? S_STCLR : S_INSWR;
				S_INSWR: state_q <= S_INSRD;
				S_DELRD: state_q <= sts.del_end ? S_STCLR : S_DELWR;
				S_DELWR: state_q <= S_DELRD;
				S_FRD:   state_q <= sts.idx_end ? S_LRD : S_FWAIT;
				S_FWAIT: state_q <= sts.k_ge ? S_LRD : S_FRD;
				S_LRD:   state_q <= sts.k_zero ? S_FDEC : S_LWAIT;
				S_LWAIT: state_q <= S_FDEC;
				S_FDEC: begin
					if (sts.f_both)
						state_q <= S_DELRD;
					else if (sts.f_none)
						state_q <= S_INSRD;
					else
						state_q <= S_STCLR;
				end
				S_STCLR: state_q <= S_STRD;
				S_STRD: begin
					if (sts.idx_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_STACC;
					end
				end
				S_STACC: state_q <= S_STRD;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule

// ===== sim/aligned_range_allocator_checker.sv =====
// Checker for the aligned range allocator: tracks the capacity register,
// predicts every accepted request and compares each result strobe.
// Depends on ara_pkg.
`timescale 1ns / 1ps

module aligned_range_allocator_checker
	import ara_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [2:0]       req_type,
	input  logic [SZ_W-1:0]  req_bytes,
	input  logic [AL_W-1:0]  req_alignment,
	input  logic [OFF_W-1:0] req_offset,
	input  logic [OFF_W-1:0] min_offset,
	input  logic             cfg_we,
	input  logic [SZ_W-1:0]  cfg_wdata,
	input  logic             done,
	input  logic [1:0]       status,
	input  logic [OFF_W-1:0] result_offset,
	input  logic [SZ_W-1:0]  free_bytes,
	input  logic [SZ_W-1:0]  largest_free,
	input  logic [SZ_W-1:0]  free_prefix,
	input  logic [SZ_W-1:0]  peak_used,
	output int               errors,
	output int               pending
);

	typedef struct {
		logic [1:0]       st;
		logic [OFF_W-1:0] off;
		logic [SZ_W-1:0]  fb;
		logic [SZ_W-1:0]  lf;
		logic [SZ_W-1:0]  fp;
		logic [SZ_W-1:0]  pk;
	} alloc_result_t;

	localparam logic [63:0] SPAN64 = 64'd1 << OFF_W;
	localparam logic [63:0] USED_MAX = (64'd1 << SZ_W) - 1;

	logic [63:0] cap;
	logic [63:0] fr_start [MAX_RANGES];
	logic [63:0] fr_size [MAX_RANGES];
	int          fr_cnt;
	logic [63:0] used;
	logic [63:0] peak;
	alloc_result_t result_q[$];

	assign pending = result_q.size();

	task automatic drop_range(input int i);
		for (int j = i; j < fr_cnt - 1; j++) begin
			fr_start[j] = fr_start[j+1];
			fr_size[j] = fr_size[j+1];
		end
		fr_cnt--;
	endtask

	task automatic insert_range(input int i, input logic [63:0] s, input logic [63:0] z);
		for (int j = fr_cnt; j > i; j--) begin
			fr_start[j] = fr_start[j-1];
			fr_size[j] = fr_size[j-1];
		end
		fr_start[i] = s;
		fr_size[i] = z;
		fr_cnt++;
	endtask

	task automatic take_bytes(input int i, input logic [63:0] at, input logic [63:0] nb,
			output logic [1:0] st);
		logic [63:0] lead, trail;
		lead = at - fr_start[i];
		trail = fr_size[i] - lead - nb;
		st = ST_OK;
		if (lead != 0 && trail != 0) begin
			if (fr_cnt >= MAX_RANGES) begin
				st = ST_FULL;
				return;
			end
			fr_size[i] = lead;
			insert_range(i + 1, at + nb, trail);
		end else if (lead != 0) begin
			fr_size[i] = lead;
		end else if (trail != 0) begin
			fr_start[i] = at + nb;
			fr_size[i] = trail;
		end else begin
			drop_range(i);
		end
		used = used + nb;
		if (used > USED_MAX) used = USED_MAX;
		if (used > peak) peak = used;
	endtask

	task automatic predict_request(input logic [2:0] rt, input logic [63:0] nb,
			input logic [63:0] al, input logic [63:0] off, input logic [63:0] mo,
			output alloc_result_t r);
		logic [1:0]  st;
		logic [63:0] res, s, z, e, at, lo, sel_at, sel_size, largest, prefix;
		logic        found, better;
		int          sel, k;
		st = ST_OK;
		res = 0;
		found = 0;
		sel = 0;
		sel_at = 0;
		sel_size = 0;
		if (rt <= RQ_HIGH) begin
			if (al == 0) begin
				st = ST_BAD;
			end else begin
				for (int i = 0; i < fr_cnt; i++) begin
					s = fr_start[i];
					z = fr_size[i];
					e = s + z;
					if (rt <= RQ_BEST_LO) begin
						at = (s % al == 0) ? s : s + (al - s % al);
						if (at - s > z || nb > z - (at - s)) continue;
						if (rt == RQ_FIRST) begin
							found = 1; sel = i; sel_at = at;
							break;
						end
						better = !found || z < sel_size || (z == sel_size && at < sel_at);
					end else if (rt == RQ_BEST_HI) begin
						if (nb > z) continue;
						at = (e - nb) - (e - nb) % al;
						if (at < s) continue;
						better = !found || z < sel_size || (z == sel_size && at > sel_at);
					end else begin
						lo = s > mo ? s : mo;
						if (lo > e || nb > e - lo) continue;
						at = (e - nb) - (e - nb) % al;
						if (at < lo) continue;
						better = !found || at > sel_at;
					end
					if (better) begin
						found = 1; sel = i; sel_at = at; sel_size = z;
					end
				end
				if (!found) begin
					st = ST_NOFIT;
				end else begin
					take_bytes(sel, sel_at, nb, st);
					if (st == ST_OK) res = sel_at;
				end
			end
		end else if (rt == RQ_RESERVE) begin
			if (nb == 0 || off > cap || nb > cap - off) begin
				st = ST_BAD;
			end else begin
				st = ST_NOFIT;
				for (int i = 0; i < fr_cnt; i++) begin
					if (off < fr_start[i]) break;
					lo = off - fr_start[i];
					if (lo <= fr_size[i] && nb <= fr_size[i] - lo) begin
						take_bytes(i, off, nb, st);
						if (st == ST_OK) res = off;
						break;
					end
				end
			end
		end else if (rt == RQ_FREE) begin
			if (nb == 0) begin
				st = ST_OK;
			end else if (off > SPAN64 || nb > SPAN64 - off) begin
				st = ST_BAD;
			end else if (fr_cnt >= MAX_RANGES) begin
				st = ST_FULL;
			end else begin
				k = 0;
				while (k < fr_cnt && fr_start[k] < off) k++;
				insert_range(k, off, nb);
				if (k + 1 < fr_cnt && fr_start[k] + fr_size[k] == fr_start[k+1]) begin
					fr_size[k] = fr_size[k] + fr_size[k+1];
					drop_range(k + 1);
				end
				if (k > 0 && fr_start[k-1] + fr_size[k-1] == fr_start[k]) begin
					fr_size[k-1] = fr_size[k-1] + fr_size[k];
					drop_range(k);
				end
				used = used > nb ? used - nb : 0;
			end
		end else if (rt == RQ_INIT) begin
			used = 0;
			peak = 0;
			fr_cnt = 0;
			if (cap != 0) begin
				fr_start[0] = 0;
				fr_size[0] = cap;
				fr_cnt = 1;
			end
		end
		largest = 0;
		prefix = 0;
		for (int i = 0; i < fr_cnt; i++)
			if (fr_size[i] > largest) largest = fr_size[i];
		if (fr_cnt > 0 && fr_start[0] == 0) prefix = fr_size[0];
		r.st = st;
		r.off = res[OFF_W-1:0];
		r.fb = cap > used ? SZ_W'(cap - used) : '0;
		r.lf = largest[SZ_W-1:0];
		r.fp = prefix[SZ_W-1:0];
		r.pk = peak[SZ_W-1:0];
	endtask

	initial begin
		errors = 0;
		cap = 0;
		fr_cnt = 0;
		used = 0;
		peak = 0;
	end

	always @(posedge clk) begin
		alloc_result_t want, got;
		if (arst_n) begin
			if (done) begin
				if (result_q.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					want = result_q.pop_front();
					if (status !== want.st) begin
						$error("status expected %0d actual %0d", want.st, status);
						errors++;
					end
					if (result_offset !== want.off) begin
						$error("result_offset expected %0h actual %0h", want.off, result_offset);
						errors++;
					end
					if (free_bytes !== want.fb) begin
						$error("free_bytes expected %0h actual %0h", want.fb, free_bytes);
						errors++;
					end
					if (largest_free !== want.lf) begin
						$error("largest_free expected %0h actual %0h", want.lf, largest_free);
						errors++;
					end
					if (free_prefix !== want.fp) begin
						$error("free_prefix expected %0h actual %0h", want.fp, free_prefix);
						errors++;
					end
					if (peak_used !== want.pk) begin
						$error("peak_used expected %0h actual %0h", want.pk, peak_used);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				predict_request(req_type, 64'(req_bytes), 64'(req_alignment),
					64'(req_offset), 64'(min_offset), got);
				result_q.push_back(got);
			end
			if (cfg_we)
				cap = (64'(cfg_wdata) > SPAN64) ? SPAN64 : 64'(cfg_wdata);
		end
	end

endmodule

// ===== sim/aligned_range_allocator_core_tb.sv =====
// Testbench top for aligned_range_allocator_core: clock, reset, request and
// capacity stimulus, watchdog and verdict. Depends on ara_pkg, the core and the checker.
`timescale 1ns / 1ps

module aligned_range_allocator_core_tb;
	import ara_pkg::*;

	localparam int STALL_LIMIT = 40000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [2:0]       req_type;
	logic [SZ_W-1:0]  req_bytes;
	logic [AL_W-1:0]  req_alignment;
	logic [OFF_W-1:0] req_offset;
	logic [OFF_W-1:0] min_offset;
	logic             cfg_we;
	logic [SZ_W-1:0]  cfg_wdata;
	logic             done;
	logic [1:0]       status;
	logic [OFF_W-1:0] result_offset;
	logic [SZ_W-1:0]  free_bytes, largest_free, free_prefix, peak_used;
	int               errors, pending;
	logic [63:0]      cap_now;
	bit               no_idle;

	aligned_range_allocator_core DUT (.*);

	aligned_range_allocator_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((start && !busy) || done || cfg_we || !arst_n) idle = 0;
			else idle++;
			if (idle >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rnd64();
		return {32'($urandom), 32'($urandom)};
	endfunction

	// small sizes mostly, full-width noise now and then
	function automatic logic [63:0] rnd_upto(input logic [63:0] lim);
		if ($urandom_range(0, 19) == 0) return rnd64();
		if (lim == 0) return 64'($urandom_range(0, 15));
		return rnd64() % (lim + 1);
	endfunction

	function automatic logic [63:0] rnd_align();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return rnd64() & ((64'd1 << AL_W) - 1);
			2:       return 64'($urandom_range(1, 1000));
			default: return 64'd1 << $urandom_range(0, 12);
		endcase
	endfunction

	task automatic send_request(input logic [2:0] rt, input logic [63:0] nb,
			input logic [63:0] al, input logic [63:0] off, input logic [63:0] mo);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 23) begin
				@(negedge clk);
				start = 0;
			end
		end
		@(negedge clk);
		start = 1;
		req_type = rt;
		req_bytes = nb[SZ_W-1:0];
		req_alignment = al[AL_W-1:0];
		req_offset = off[OFF_W-1:0];
		min_offset = mo[OFF_W-1:0];
		do @(posedge clk); while (busy);
	endtask

	// write capacity only once the block has drained
	task automatic set_capacity(input logic [63:0] v);
		@(negedge clk);
		start = 0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1;
		cfg_wdata = v[SZ_W-1:0];
		@(negedge clk);
		cfg_we = 0;
		cap_now = (v[SZ_W-1:0] > SPAN) ? 64'(SPAN) : 64'(v[SZ_W-1:0]);
	endtask

	task automatic random_request();
		logic [63:0] c;
		c = cap_now;
		case ($urandom_range(0, 9))
			0, 1: send_request(RQ_FIRST, rnd_upto(c / 8), rnd_align(), rnd64(), rnd64());
			2:    send_request(RQ_BEST_LO, rnd_upto(c / 8), rnd_align(), rnd64(), rnd64());
			3:    send_request(RQ_BEST_HI, rnd_upto(c / 8), rnd_align(), rnd64(), rnd64());
			4:    send_request(RQ_HIGH, rnd_upto(c / 8), rnd_align(), rnd64(), rnd_upto(c));
			5:    send_request(RQ_RESERVE, rnd_upto(c / 8), rnd64(), rnd_upto(c), rnd64());
			6, 7: send_request(RQ_FREE, rnd_upto(c / 8), rnd64(), rnd_upto(c), rnd64());
			8:    send_request(RQ_QUERY, rnd64(), rnd64(), rnd64(), rnd64());
			default: begin
				if ($urandom_range(0, 3) == 0)
					send_request(RQ_INIT, rnd64(), rnd64(), rnd64(), rnd64());
				else
					send_request(RQ_FIRST, rnd_upto(c / 4), 64'd1, 0, 0);
			end
		endcase
	endtask

	initial begin
		int n;
		start = 0;
		req_type = RQ_QUERY;
		req_bytes = '0;
		req_alignment = '0;
		req_offset = '0;
		min_offset = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		cap_now = 0;
		no_idle = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// empty table, zero capacity: the allocation misses, the reserve is rejected
		send_request(RQ_QUERY, 0, 0, 0, 0);
		send_request(RQ_FIRST, 1, 1, 0, 0);
		send_request(RQ_INIT, 0, 0, 0, 0);
		send_request(RQ_RESERVE, 1, 1, 0, 0);

		set_capacity(4096);
		send_request(RQ_INIT, 0, 0, 0, 0);
		send_request(RQ_FIRST, 100, 1, 0, 0);
		send_request(RQ_BEST_LO, 50, 64, 0, 0);
		send_request(RQ_BEST_HI, 70, 32, 0, 0);
		send_request(RQ_HIGH, 10, 16, 0, 1000);
		send_request(RQ_RESERVE, 200, 0, 2000, 0);
		send_request(RQ_RESERVE, 200, 0, 2000, 0);     // not free any more
		send_request(RQ_FIRST, 8, 0, 0, 0);            // zero alignment
		send_request(RQ_RESERVE, 0, 1, 10, 0);         // zero bytes
		send_request(RQ_RESERVE, 10, 1, 4090, 0);      // past capacity
		send_request(RQ_FREE, 0, 0, 5, 0);             // zero-byte free
		send_request(RQ_FREE, 2, 0, {OFF_W{1'b1}}, 0); // past offset space
		send_request(RQ_FREE, 200, 0, 2000, 0);
		send_request(RQ_FREE, 4000, 0, 9000, 0);       // more than used
		send_request(RQ_FIRST, 5000, {1'b1, 32'd0}, 0, 0);
		send_request(RQ_QUERY, {SZ_W{1'b1}}, {AL_W{1'b1}}, {OFF_W{1'b1}}, {OFF_W{1'b1}});

		set_capacity({SZ_W{1'b1}}); // held at the full span
		send_request(RQ_INIT, 0, 0, 0, 0);
		send_request(RQ_BEST_HI, 0, 1, 0, 0);          // zero bytes at top wraps
		send_request(RQ_HIGH, 64'(SPAN), 1, 0, 0);
		send_request(RQ_FREE, 64'(SPAN), 0, 0, 0);

		n = 0;
		while (n < 140) begin
			case ((n / 35) % 4)
				0: set_capacity(64'($urandom_range(64, 65536)));
				1: set_capacity(rnd64() & ((64'd1 << SZ_W) - 1));
				2: set_capacity(0);
				default: set_capacity(64'(SPAN));
			endcase
			send_request(RQ_INIT, rnd64(), rnd64(), rnd64(), rnd64());
			n++;
			no_idle = ((n / 35) == 2);
			if (cap_now == 0) begin
				// fragment: scattered frees until the table is full
				for (int i = 0; i < 66; i++) begin
					send_request(RQ_FREE, 2, 0, 64'(i) * 8, 0);
					n++;
				end
				send_request(RQ_FIRST, 1, 4, 0, 0);    // takes from a range on a full table, no split
				send_request(RQ_BEST_HI, 1, 1, 0, 0);
				send_request(RQ_RESERVE, 1, 0, 9, 0);
				n += 3;
				for (int i = 0; i < 10; i++) begin
					random_request();
					n++;
				end
			end else begin
				for (int i = 0; i < 34; i++) begin
					random_request();
					n++;
				end
			end
		end
		no_idle = 0;

		@(negedge clk);
		start = 0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ara_pkg.sv
rtl/ara_div.sv
rtl/ara_dp.sv
rtl/ara_ctrl.sv
rtl/aligned_range_allocator_core.sv
sim/aligned_range_allocator_checker.sv
sim/aligned_range_allocator_core_tb.sv
